// ===== sv/ies_pkg.sv =====
// shared constants, codes and control types of the interference edge store
`default_nettype none

package ies_pkg;

  localparam int NODES     = 64;
  localparam int ID_W      = 6;
  localparam int CNT_W     = 7;
  localparam int SLOT_W    = 6;
  localparam int DEG_W     = 6;
  localparam int IDX_W     = 11;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int MAT_WORDS = (NODES * (NODES - 1) / 2 + WORD_W - 1) / WORD_W;
  localparam int MADDR_W   = IDX_W - BIT_W;
  localparam int LADDR_W   = ID_W + SLOT_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_SELF  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the request word
    logic issue_rd;  // read matrix word, degrees and list entry
    logic eval;      // check, build result, first update write
    logic wr2;       // second update write (node_b side)
    logic load_out;  // move result into the output register
  } ies_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ins_ok;    // insert passes all checks (valid during eval)
    logic out_free;  // output register can take a result
  } ies_stat_t;

endpackage

`default_nettype wire

// ===== sv/interference_edge_store_top.sv =====
// top level of the interference edge store
//
//  channel  ports                          word contents (low bit first)
//  in       in_tvalid/in_tready/in_tdata   node_a, node_b, slot; in_tuser = req_type
//  out      out_tvalid/out_tready/out_tdata status, edge_present, degree_a,
//                                           degree_b, neighbour
//  cfg      cfg_we/cfg_wdata               node_count
//
//  one request word takes the sequencer through these steps (the second write-back only for a good insert):
//  capture, read of matrix word / degrees / list entry, check with first
//  write-back, second write-back for the node_b side, handoff to output
//  the result word becomes valid in the output register at handoff
//  the single write port of the degree and list memories is why a good insert needs the second write-back
//  reset clears the matrix and degrees at once through per-word and per-node valid bits
//  a stalled output holds the sequencer before handoff while the output register is still full;
//  a new word is taken while the previous result still waits in the output register
`default_nettype none

module interference_edge_store_top
  import ies_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request words
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // node_a[5:0], node_b[11:6], slot[17:12]
  input  wire logic [1:0]            in_tuser,   // req_type[1:0]
  // result words
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // status[1:0], edge_present[2],
                                                 // degree_a[8:3], degree_b[14:9],
                                                 // neighbour[20:15]
  // node_count register
  input  wire logic                  cfg_we,
  input  wire logic [CNT_W-1:0]      cfg_wdata
);

  ies_cmd_t  cmd;
  ies_stat_t stat;

  // sequencer
  ies_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage, checks and output register
  ies_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (in_tuser),
    .node_a     (in_tdata[ID_W-1:0]),
    .node_b     (in_tdata[2*ID_W-1:ID_W]),
    .slot       (in_tdata[2*ID_W+SLOT_W-1:2*ID_W]),
    .cfg_we     (cfg_we),
    .cfg_count  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== sv/ies_ctrl.sv =====
// request sequencer of the interference edge store
`default_nettype none

module ies_ctrl
  import ies_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire ies_stat_t stat,
  output ies_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_WR2  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        cmd.issue_rd = 1'b1;
        state_nxt    = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.ins_ok ? S_WR2 : S_DONE;
      end
      S_WR2: begin
        cmd.wr2   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ies_dp.sv =====
// datapath of the interference edge store: matrix, degrees, lists, result
`default_nettype none

module ies_dp
  import ies_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ies_cmd_t              cmd,
  output ies_stat_t                  stat,
  input  wire logic [1:0]            req_type,
  input  wire logic [ID_W-1:0]       node_a,
  input  wire logic [ID_W-1:0]       node_b,
  input  wire logic [SLOT_W-1:0]     slot,
  input  wire logic                  cfg_we,
  input  wire logic [CNT_W-1:0]      cfg_count,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  // memories
  logic [WORD_W-1:0] mat_mem [MAT_WORDS];
  logic [MAT_WORDS-1:0] mat_vld_r;
  logic [DEG_W-1:0]  deg_mem [NODES];
  logic [NODES-1:0]  deg_vld_r;
  logic [ID_W-1:0]   list_mem [NODES * NODES];

  // request
  logic [1:0]        req_r;
  logic [ID_W-1:0]   a_r, b_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  cnt_r;

  // read side
  logic [MADDR_W-1:0] waddr_r;
  logic [BIT_W-1:0]   bsel_r;
  logic [WORD_W-1:0]  mat_q_r;
  logic               mat_v_r;
  logic [DEG_W-1:0]   dega_q_r, degb_q_r;
  logic               dega_v_r, degb_v_r;
  logic [ID_W-1:0]    list_q_r;

  // result and output
  logic [1:0]       res_st_r;
  logic             res_pr_r;
  logic [DEG_W-1:0] res_da_r, res_db_r;
  logic [ID_W-1:0]  res_nb_r;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // pair index
  logic [ID_W-1:0]      row, col;
  logic [2*ID_W-1:0]    row_w, prod, tri_idx;
  logic [IDX_W-1:0]     idx;

  always_comb begin
    row     = (a_r > b_r) ? a_r : b_r;
    col     = (a_r > b_r) ? b_r : a_r;
    row_w   = {{ID_W{1'b0}}, row};
    prod    = row_w * (row_w - {{(2*ID_W-1){1'b0}}, 1'b1});
    tri_idx = (prod >> 1) + {{ID_W{1'b0}}, col};
    idx     = tri_idx[IDX_W-1:0];
  end

  // evaluation
  logic [CNT_W-1:0]  lim;
  logic              a_ok, b_ok, in_rng, self_lp, present;
  logic [WORD_W-1:0] word;
  logic [DEG_W-1:0]  da, db;
  logic              ins_ok;
  logic [1:0]        st;
  logic              pr;
  logic [DEG_W-1:0]  oda, odb;
  logic [ID_W-1:0]   onb;

  always_comb begin
    lim     = (cnt_r > CNT_W'(NODES)) ? CNT_W'(NODES) : cnt_r;
    a_ok    = {1'b0, a_r} < lim;
    b_ok    = {1'b0, b_r} < lim;
    in_rng  = a_ok && b_ok;
    self_lp = (a_r == b_r);
    word    = mat_v_r ? mat_q_r : '0;
    present = word[bsel_r];
    da      = dega_v_r ? dega_q_r : '0;
    db      = degb_v_r ? degb_q_r : '0;
    ins_ok  = (req_r == REQ_INSERT) && in_rng && !self_lp && !present;
    st  = ST_OK;
    pr  = 1'b0;
    oda = '0;
    odb = '0;
    onb = '0;
    case (req_r)
      REQ_READ: begin
        oda = da;
        if (!a_ok || (slot_r >= da)) begin
          st = ST_RANGE;
        end else begin
          onb = list_q_r;
        end
      end
      REQ_INSERT, REQ_QUERY: begin
        oda = da + DEG_W'(ins_ok);
        odb = db + DEG_W'(ins_ok);
        if (!in_rng) begin
          st = ST_RANGE;
        end else if (self_lp) begin
          st = ST_SELF;
        end else begin
          pr = present;
          if ((req_r == REQ_INSERT) && present) begin
            st = ST_DUP;
          end
        end
      end
      default: begin
        st = ST_RANGE;
      end
    endcase
  end

  assign stat.ins_ok   = ins_ok;
  assign stat.out_free = !out_valid_r || out_tready;

  // update write port selection: node_a side in eval, node_b side in wr2
  logic                deg_we;
  logic [ID_W-1:0]     deg_wa;
  logic [DEG_W-1:0]    deg_wd;
  logic [LADDR_W-1:0]  list_wa;
  logic [ID_W-1:0]     list_wd;
  logic                mat_we;

  always_comb begin
    mat_we  = cmd.eval && ins_ok;
    deg_we  = mat_we || cmd.wr2;
    deg_wa  = cmd.wr2 ? b_r : a_r;
    deg_wd  = cmd.wr2 ? (db + DEG_W'(1)) : (da + DEG_W'(1));
    list_wa = cmd.wr2 ? {b_r, db} : {a_r, da};
    list_wd = cmd.wr2 ? a_r : b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= CNT_W'(NODES);
      mat_vld_r <= '0;
      deg_vld_r <= '0;
    end else begin
      if (cfg_we) begin
        cnt_r <= cfg_count;
      end
      if (mat_we) begin
        mat_vld_r[waddr_r] <= 1'b1;
      end
      if (deg_we) begin
        deg_vld_r[deg_wa] <= 1'b1;
      end
    end
  end

  // request capture and memory reads
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_type;
      a_r    <= node_a;
      b_r    <= node_b;
      slot_r <= slot;
    end
    if (cmd.issue_rd) begin
      waddr_r  <= idx[IDX_W-1:BIT_W];
      bsel_r   <= idx[BIT_W-1:0];
      mat_q_r  <= mat_mem[idx[IDX_W-1:BIT_W]];
      mat_v_r  <= mat_vld_r[idx[IDX_W-1:BIT_W]];
      dega_q_r <= deg_mem[a_r];
      dega_v_r <= deg_vld_r[a_r];
      degb_q_r <= deg_mem[b_r];
      degb_v_r <= deg_vld_r[b_r];
      list_q_r <= list_mem[{a_r, slot_r}];
    end
    if (mat_we) begin
      mat_mem[waddr_r] <= word | (WORD_W'(1) << bsel_r);
    end
    if (deg_we) begin
      deg_mem[deg_wa]   <= deg_wd;
      list_mem[list_wa] <= list_wd;
    end
    if (cmd.eval) begin
      res_st_r <= st;
      res_pr_r <= pr;
      res_da_r <= oda;
      res_db_r <= odb;
      res_nb_r <= onb;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {3'b000, res_nb_r, res_db_r, res_da_r, res_pr_r, res_st_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// self-checking interference edge store testbench: directed and random traffic vs a graph predictor
`timescale 1ns / 100ps

module tb;
  import ies_pkg::*;

  // request type with no meaning in the block, answered as out of range
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   node_a;
    logic [ID_W-1:0]   node_b;
    logic [SLOT_W-1:0] slot;
  } graph_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             edge_present;
    logic [DEG_W-1:0] degree_a;
    logic [DEG_W-1:0] degree_b;
    logic [ID_W-1:0]  neighbour;
  } graph_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata = '0;

  interference_edge_store_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // shadow copy of the graph: triangular edge matrix, degrees, neighbour lists
  logic             edge_bit [0:NODES*(NODES-1)/2-1];
  logic [DEG_W-1:0] node_deg [0:NODES-1];
  logic [ID_W-1:0]  adj_list [0:NODES-1][0:NODES-1];
  logic [CNT_W-1:0] node_limit = CNT_W'(NODES);

  graph_req_t    request_queue[$];    // words waiting for the driver
  graph_result_t awaited_results[$];  // predicted result words, oldest first
  graph_req_t    drv_req;             // word currently on the input channel
  logic          in_taken = 1'b0;     // input handshake seen at the last rising edge
  int            send_gap = 0;
  int            stall_left = 0;
  bit            quiet = 1'b0;        // phase without any idling on either side
  int            mismatches = 0;

  // apply one request to the shadow graph and return the result word it yields
  function automatic graph_result_t graph_apply(graph_req_t r);
    graph_result_t res;
    int            lim;
    int            row, col, pos;
    logic          a_ok, b_ok;
    res  = '0;
    lim  = (node_limit < NODES) ? int'(node_limit) : NODES;
    a_ok = int'(r.node_a) < lim;
    b_ok = int'(r.node_b) < lim;
    case (r.req_type)
      REQ_READ: begin
        // list entries at or past the degree were never written
        if (!a_ok || r.slot >= node_deg[r.node_a]) res.status = ST_RANGE;
        else res.neighbour = adj_list[r.node_a][r.slot];
        res.degree_a = node_deg[r.node_a];
      end
      REQ_INSERT, REQ_QUERY: begin
        // range check wins over self loop, which wins over duplicate
        if (!a_ok || !b_ok) begin
          res.status = ST_RANGE;
        end else if (r.node_a == r.node_b) begin
          res.status = ST_SELF;
        end else begin
          row = (r.node_a > r.node_b) ? int'(r.node_a) : int'(r.node_b);
          col = (r.node_a > r.node_b) ? int'(r.node_b) : int'(r.node_a);
          pos = row * (row - 1) / 2 + col;
          res.edge_present = edge_bit[pos];
          if (r.req_type == REQ_INSERT) begin
            if (edge_bit[pos]) begin
              res.status = ST_DUP;
            end else begin
              edge_bit[pos] = 1'b1;
              adj_list[r.node_a][node_deg[r.node_a]] = r.node_b;
              adj_list[r.node_b][node_deg[r.node_b]] = r.node_a;
              node_deg[r.node_a] = node_deg[r.node_a] + 1'b1;
              node_deg[r.node_b] = node_deg[r.node_b] + 1'b1;
            end
          end
        end
        // degrees are reported even for ids flagged out of range
        res.degree_a = node_deg[r.node_a];
        res.degree_b = node_deg[r.node_b];
      end
      default: res.status = ST_RANGE;
    endcase
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // sampling at the rising edge: results are checked first, then an accepted
  // request word is run through the predictor
  always @(posedge clk) begin
    graph_result_t exp_res;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with no request awaiting it");
          mismatches++;
        end else begin
          exp_res = awaited_results.pop_front();
          check_field("status", exp_res.status, out_tdata[1:0]);
          check_field("edge_present", exp_res.edge_present, out_tdata[2]);
          check_field("degree_a", exp_res.degree_a, out_tdata[8:3]);
          check_field("degree_b", exp_res.degree_b, out_tdata[14:9]);
          check_field("neighbour", exp_res.neighbour, out_tdata[20:15]);
        end
      end
      if (in_tvalid && in_tready) awaited_results.push_back(graph_apply(drv_req));
    end
  end

  // request driver: holds a word until taken, then idles for a random gap
  always @(negedge clk) begin
    graph_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // word still waiting for in_tready
    end else if (send_gap != 0) begin
      in_tvalid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (request_queue.size() != 0) begin
      nxt = request_queue.pop_front();
      drv_req   <= nxt;
      in_tdata  <= {6'b0, nxt.slot, nxt.node_b, nxt.node_a};
      in_tuser  <= nxt.req_type;
      in_tvalid <= 1'b1;
      send_gap  <= gap_len();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result sink: random back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= gap_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_req(logic [1:0] t, int a, int b, int s);
    graph_req_t r;
    r.req_type = t;
    r.node_a   = ID_W'(a);
    r.node_b   = ID_W'(b);
    r.slot     = SLOT_W'(s);
    request_queue.push_back(r);
  endtask

  // sender holds off until every word sent so far has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_tvalid || awaited_results.size() != 0);
  endtask

  // node_count is only written with the store idle
  task automatic set_node_count(int v);
    wait_drained();
    @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= CNT_W'(v);
    node_limit  = CNT_W'(v);
    @(negedge clk);
    cfg_we     <= 1'b0;
    quiet       = ($urandom_range(0, 3) == 0);
  endtask

  // ids mostly inside the active range so that inserts get past the checks
  function automatic int pick_id(int lim);
    if (lim > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, lim - 1);
    return $urandom_range(0, 63);
  endfunction

  task automatic push_random(int n);
    int         lim, r, a, b, s;
    logic [1:0] t;
    lim = (node_limit < NODES) ? int'(node_limit) : NODES;
    repeat (n) begin
      r = $urandom_range(0, 99);
      t = (r < 45) ? REQ_INSERT : (r < 70) ? REQ_QUERY : (r < 95) ? REQ_READ : REQ_UNUSED;
      a = pick_id(lim);
      b = pick_id(lim);
      // degrees only grow, so a slot below today's degree stays valid when sent
      if (t == REQ_READ && node_deg[a] != 0 && $urandom_range(0, 4) != 0)
        s = $urandom_range(0, node_deg[a] - 1);
      else
        s = $urandom_range(0, 63);
      push_req(t, a, b, s);
    end
  endtask

  // connect one hub to all other nodes in random order, driving its degree to the top; read its list
  task automatic push_star(int hub);
    int spokes [0:NODES-2];
    int n, j, tmp;
    n = 0;
    for (int i = 0; i < NODES; i++) begin
      if (i != hub) begin
        spokes[n] = i;
        n++;
      end
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = spokes[i];
      spokes[i] = spokes[j];
      spokes[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) != 0) push_req(REQ_INSERT, hub, spokes[i], $urandom_range(0, 63));
      else push_req(REQ_INSERT, spokes[i], hub, $urandom_range(0, 63));
    end
    repeat (20) push_req(REQ_READ, hub, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  initial begin
    for (int i = 0; i < NODES * (NODES - 1) / 2; i++) edge_bit[i] = 1'b0;
    for (int i = 0; i < NODES; i++) node_deg[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: full range of ids
    set_node_count(64);
    push_req(REQ_QUERY, 0, 1, 0);        // empty graph
    push_req(REQ_INSERT, 0, 1, 0);
    push_req(REQ_INSERT, 1, 0, 0);       // duplicate, pair given reversed
    push_req(REQ_QUERY, 1, 0, 0);        // existing edge
    push_req(REQ_INSERT, 5, 5, 0);       // self loop
    push_req(REQ_INSERT, 63, 0, 0);      // extreme ids
    push_req(REQ_INSERT, 62, 63, 0);
    push_req(REQ_QUERY, 63, 62, 0);
    push_req(REQ_READ, 0, 0, 0);
    push_req(REQ_READ, 63, 0, 1);
    push_req(REQ_READ, 0, 63, 2);        // slot at the degree
    push_req(REQ_READ, 63, 0, 63);       // largest slot
    push_req(REQ_UNUSED, 63, 63, 63);
    push_req(REQ_READ, 40, 0, 0);        // empty list

    // directed: lowered limit keeps edges, flags high ids
    set_node_count(2);
    push_req(REQ_INSERT, 0, 1, 0);
    push_req(REQ_INSERT, 1, 2, 0);
    push_req(REQ_QUERY, 63, 0, 0);       // degrees still reported
    push_req(REQ_READ, 63, 0, 0);
    push_req(REQ_READ, 1, 0, 0);
    set_node_count(0);
    push_req(REQ_INSERT, 0, 1, 0);
    set_node_count(1);
    push_req(REQ_INSERT, 0, 0, 0);       // self loop with id in range
    push_req(REQ_INSERT, 1, 1, 0);       // range check comes first
    set_node_count(127);
    push_req(REQ_INSERT, 2, 3, 0);
    push_req(REQ_QUERY, 3, 2, 0);

    // random phases across several limits
    set_node_count(64);
    push_star(63);
    push_random(120);
    set_node_count($urandom_range(3, 63));
    push_random(100);
    set_node_count(8);                   // dense graph, many duplicates
    quiet = 1'b1;
    push_random(100);
    set_node_count(2);
    push_random(30);
    set_node_count(1);
    push_random(10);
    set_node_count(0);
    push_random(10);
    set_node_count(127);
    push_random(40);
    set_node_count(64);
    push_random(40);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ies_pkg.sv
sv/ies_ctrl.sv
sv/ies_dp.sv
sv/interference_edge_store_top.sv
test/tb.sv
